### rtl/multi_region_frame_crop_macros.svh
// Assertion helpers for the frame crop block.
`ifndef MULTI_REGION_FRAME_CROP_MACROS_SVH
`define MULTI_REGION_FRAME_CROP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MRFC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MRFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MRFC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define MRFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/mrfc_pkg.sv
`default_nettype none
package mrfc_pkg;

    localparam int REGION_SLOTS    = 4;
    localparam int IDX_W           = $clog2(REGION_SLOTS);
    localparam int MAX_REGIONS_DEF = 4;
    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OFS_W           = 26;
    localparam int CMP_W           = 20;
    localparam int DIM_W           = 13;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int CNT_W           = 3;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [CNT_W-1:0] COUNT_RST  = 3'd1;

    typedef enum logic [2:0] {
        FMT_I420   = 3'd0,
        FMT_NV12   = 3'd1,
        FMT_NV21   = 3'd2,
        FMT_RGB555 = 3'd3,
        FMT_RGB565 = 3'd4,
        FMT_RGB24  = 3'd5,
        FMT_RGB32  = 3'd6
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_PIXEL_FORMAT = 3'd2,
        CFG_REGION_COUNT = 3'd3,
        CFG_RECT_ZERO    = 3'd4,
        CFG_RECT_ONE     = 3'd5,
        CFG_RECT_TWO     = 3'd6,
        CFG_RECT_THREE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]                         sample;
        logic [REGION_SLOTS-1:0]            hit_mask;
        logic [REGION_SLOTS-1:0][OFS_W-1:0] offsets;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage
`default_nettype wire

### rtl/mrfc_front.sv
`default_nettype none
module mrfc_front #(
    parameter int MAX_REGIONS = mrfc_pkg::MAX_REGIONS_DEF,
    parameter int MAX_DIM     = mrfc_pkg::MAX_DIM_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mrfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrfc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_sample_byte,
    input  wire logic                              s_frame_start,
    input  wire mrfc_pkg::q_stat_t                 q_stat,
    output logic                                   push_valid,
    output mrfc_pkg::entry_t                       push_entry
);

    localparam int ROW_W = $clog2(MAX_DIM);
    localparam int COL_W = ROW_W + 2;
    localparam int CMP_W = mrfc_pkg::CMP_W;
    localparam int OFS_W = mrfc_pkg::OFS_W;
    localparam int SLOTS = mrfc_pkg::REGION_SLOTS;
    localparam int DIM_W = mrfc_pkg::DIM_W;
    localparam int CNT_W = mrfc_pkg::CNT_W;

    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [2:0]       pixel_format_reg;
    logic [CNT_W-1:0] region_count_reg;
    logic [63:0]      rect_reg [SLOTS];

    logic [1:0]       plane_reg, plane_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [OFS_W-1:0] offs_reg [SLOTS];
    logic [OFS_W-1:0] offs_next [SLOTS];
    logic [OFS_W-1:0] offs_cur [SLOTS];

    logic [1:0]       plane_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_cur;

    logic [DIM_W-1:0] w_eff, h_eff, rows;
    logic [2:0]       fmt, bpp;
    logic             rgb, chroma, i420_chroma, in_plane, accept;
    logic [1:0]       nplanes, p_eff;
    logic [CMP_W-1:0] rowbytes, lrow;
    logic [CNT_W-1:0] n_eff;
    logic [MAX_REGIONS-1:0] hit;
    logic [SLOTS-1:0]       hit_full;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(2)) begin
            r = DIM_W'(2);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [CMP_W-1:0] scale_bpp(input logic [CMP_W-1:0] v,
                                                   input logic [2:0] b);
        logic [CMP_W-1:0] r;
        case (b)
            3'd3:    r = (v << 1) + v;
            3'd4:    r = v << 2;
            default: r = v << 1;
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= mrfc_pkg::WIDTH_RST;
            frame_height_reg <= mrfc_pkg::HEIGHT_RST;
            pixel_format_reg <= mrfc_pkg::FMT_I420;
            region_count_reg <= mrfc_pkg::COUNT_RST;
            for (int i = 0; i < SLOTS; i++) begin
                rect_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mrfc_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[DIM_W-1:0];
                mrfc_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[DIM_W-1:0];
                mrfc_pkg::CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_wr_data[2:0];
                mrfc_pkg::CFG_REGION_COUNT: region_count_reg <= cfg_wr_data[CNT_W-1:0];
                mrfc_pkg::CFG_RECT_ZERO:    rect_reg[0] <= cfg_wr_data;
                mrfc_pkg::CFG_RECT_ONE:     rect_reg[1] <= cfg_wr_data;
                mrfc_pkg::CFG_RECT_TWO:     rect_reg[2] <= cfg_wr_data;
                mrfc_pkg::CFG_RECT_THREE:   rect_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_stat.full;

    // frame start clears position and offsets ahead of this beat
    always_comb begin
        plane_cur = s_frame_start ? 2'd0 : plane_reg;
        row_cur   = s_frame_start ? '0 : row_reg;
        col_cur   = s_frame_start ? '0 : col_reg;
        for (int i = 0; i < SLOTS; i++) begin
            offs_cur[i] = s_frame_start ? '0 : offs_reg[i];
        end
    end

    always_comb begin
        w_eff = clamp_dim(frame_width_reg);
        h_eff = clamp_dim(frame_height_reg);
        fmt   = (pixel_format_reg > mrfc_pkg::FMT_RGB32) ? mrfc_pkg::FMT_I420
                                                         : pixel_format_reg;
        rgb   = fmt >= mrfc_pkg::FMT_RGB555;
        if (rgb) begin
            nplanes = 2'd1;
        end else if (fmt == mrfc_pkg::FMT_I420) begin
            nplanes = 2'd3;
        end else begin
            nplanes = 2'd2;
        end
        p_eff  = (plane_cur < nplanes) ? plane_cur : nplanes - 2'd1;
        chroma = !rgb && (p_eff != 2'd0);
        i420_chroma = chroma && (fmt == mrfc_pkg::FMT_I420);
        case (fmt)
            mrfc_pkg::FMT_RGB24: bpp = 3'd3;
            mrfc_pkg::FMT_RGB32: bpp = 3'd4;
            default:             bpp = 3'd2;
        endcase
        if (rgb) begin
            rowbytes = scale_bpp(CMP_W'(w_eff), bpp);
            rows     = h_eff;
        end else if (!chroma) begin
            rowbytes = CMP_W'(w_eff);
            rows     = h_eff;
        end else begin
            rowbytes = i420_chroma ? CMP_W'(w_eff >> 1) : CMP_W'(w_eff);
            rows     = h_eff >> 1;
        end
        in_plane = (CMP_W'(row_cur) < CMP_W'(rows)) && (CMP_W'(col_cur) < rowbytes);
        lrow     = chroma ? (CMP_W'(row_cur) << 1) : CMP_W'(row_cur);
        n_eff    = (32'(region_count_reg) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                         : region_count_reg;
    end

    for (genvar j = 0; j < MAX_REGIONS; j++) begin : g_region
        logic [15:0] x0, y0, x1, y1, tly, bry, tlx_raw, brx_raw, brx;
        logic [16:0] tlx;
        logic [CMP_W-1:0] lo, hi;

        always_comb begin
            x0 = rect_reg[j][15:0];
            y0 = rect_reg[j][31:16];
            x1 = rect_reg[j][47:32];
            y1 = rect_reg[j][63:48];
            tlx_raw = (x0 <= x1) ? x0 : x1;
            brx_raw = (x0 <= x1) ? x1 : x0;
            tly     = (y0 <= y1) ? y0 : y1;
            bry     = (y0 <= y1) ? y1 : y0;
            // round left edge up and right edge down to even
            tlx = {1'b0, tlx_raw} + {16'd0, tlx_raw[0]};
            brx = {brx_raw[15:1], 1'b0};
            if (rgb) begin
                lo = scale_bpp(CMP_W'(tlx), bpp);
                hi = scale_bpp(CMP_W'(brx), bpp);
            end else if (i420_chroma) begin
                lo = CMP_W'(tlx >> 1);
                hi = CMP_W'(brx >> 1);
            end else begin
                lo = CMP_W'(tlx);
                hi = CMP_W'(brx);
            end
        end

        assign hit[j] = (CNT_W'(j) < n_eff) && in_plane
                        && (lrow >= CMP_W'(tly)) && (lrow < CMP_W'(bry))
                        && (CMP_W'(col_cur) >= lo) && (CMP_W'(col_cur) < hi);
    end

    assign hit_full = SLOTS'(hit);

    always_comb begin
        plane_next = plane_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        for (int i = 0; i < SLOTS; i++) begin
            offs_next[i] = offs_reg[i];
        end
        if (accept) begin
            plane_next = plane_cur;
            row_next   = row_cur;
            for (int i = 0; i < SLOTS; i++) begin
                offs_next[i] = offs_cur[i] + OFS_W'(hit_full[i]);
            end
            if (CMP_W'(col_cur) + CMP_W'(1) >= rowbytes) begin
                col_next = '0;
                if (CMP_W'(row_cur) + CMP_W'(1) >= CMP_W'(rows)) begin
                    row_next = '0;
                    if ({1'b0, plane_cur} + 3'd1 >= {1'b0, nplanes}) begin
                        // end of frame: back to the start
                        plane_next = 2'd0;
                        for (int i = 0; i < SLOTS; i++) begin
                            offs_next[i] = '0;
                        end
                    end else begin
                        plane_next = plane_cur + 2'd1;
                    end
                end else begin
                    row_next = row_cur + ROW_W'(1);
                end
            end else begin
                col_next = col_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= 2'd0;
            row_reg   <= '0;
            col_reg   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                offs_reg[i] <= '0;
            end
        end else begin
            plane_reg <= plane_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            for (int i = 0; i < SLOTS; i++) begin
                offs_reg[i] <= offs_next[i];
            end
        end
    end

    // drop beats that no region covers
    always_comb begin
        push_valid          = accept && (|hit);
        push_entry.sample   = s_sample_byte;
        push_entry.hit_mask = hit_full;
        for (int i = 0; i < SLOTS; i++) begin
            push_entry.offsets[i] = offs_cur[i];
        end
    end

endmodule
`default_nettype wire

### rtl/mrfc_queue.sv
`default_nettype none
module mrfc_queue #(
    parameter int DEPTH = mrfc_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    input  wire mrfc_pkg::entry_t push_entry,
    input  wire logic        pop,
    output mrfc_pkg::entry_t pop_entry,
    output mrfc_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrfc_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push_valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_entry    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/mrfc_back.sv
`default_nettype none
module mrfc_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mrfc_pkg::q_stat_t             q_stat,
    input  wire mrfc_pkg::entry_t              q_entry,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mrfc_pkg::IDX_W-1:0]         m_region_index,
    output logic [7:0]                         m_out_byte,
    output logic [mrfc_pkg::OFS_W-1:0]         m_out_offset,
    output logic                               m_last_of_run
);

    localparam int SLOTS = mrfc_pkg::REGION_SLOTS;
    localparam int IDX_W = mrfc_pkg::IDX_W;

    mrfc_pkg::entry_t work_reg, work_next;
    logic             work_valid_reg, work_valid_next;
    logic [IDX_W-1:0] idx;
    logic [SLOTS-1:0] mask_rest;
    logic             beat, load;

    // lowest pending region goes first
    always_comb begin
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (work_reg.hit_mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        mask_rest = work_reg.hit_mask & (work_reg.hit_mask - SLOTS'(1));
    end

    assign m_valid        = work_valid_reg;
    assign m_region_index = idx;
    assign m_out_byte     = work_reg.sample;
    assign m_out_offset   = work_reg.offsets[idx];
    assign m_last_of_run  = (mask_rest == '0);

    assign beat  = m_valid && m_ready;
    assign load  = !work_valid_reg || (beat && m_last_of_run);
    assign q_pop = load && !q_stat.empty;

    always_comb begin
        work_valid_next = load ? !q_stat.empty : work_valid_reg;
        work_next       = work_reg;
        if (q_pop) begin
            work_next = q_entry;
        end else if (beat) begin
            work_next.hit_mask = mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
        end
    end

endmodule
`default_nettype wire

### rtl/multi_region_frame_crop.sv
// Accepts one source byte per cycle while the queue is not full; results go via the queue.
// A byte covered by k regions produces k beats on the result port, one beat per region.
// A four-entry queue between classifier and emitter absorbs overlaps; input stalls when full.
// Bytes covered by no region produce no beat; they stall only while the queue is full.
// Reset (aresetn, synchronous, active low) restores register defaults, position and offsets.
`default_nettype none
`include "multi_region_frame_crop_macros.svh"
module multi_region_frame_crop #(
    parameter int MAX_REGIONS = mrfc_pkg::MAX_REGIONS_DEF,
    parameter int MAX_DIM     = mrfc_pkg::MAX_DIM_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mrfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mrfc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_sample_byte,
    input  wire logic                            s_frame_start,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [mrfc_pkg::IDX_W-1:0]           m_region_index,
    output logic [7:0]                           m_out_byte,
    output logic [mrfc_pkg::OFS_W-1:0]           m_out_offset,
    output logic                                 m_last_of_run
);

    mrfc_pkg::q_stat_t q_stat;
    mrfc_pkg::entry_t  push_entry, pop_entry;
    logic              push_valid, q_pop;

    mrfc_front #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_DIM     (MAX_DIM)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_byte (s_sample_byte),
        .s_frame_start (s_frame_start),
        .q_stat        (q_stat),
        .push_valid    (push_valid),
        .push_entry    (push_entry)
    );

    mrfc_queue #(
        .DEPTH (mrfc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    mrfc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_entry        (pop_entry),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_region_index (m_region_index),
        .m_out_byte     (m_out_byte),
        .m_out_offset   (m_out_offset),
        .m_last_of_run  (m_last_of_run)
    );

    // results of one byte come in ascending region order
    `MRFC_ASSERT_NEXT(a_region_order, aclk, aresetn, m_valid && m_ready && !m_last_of_run, m_valid && (m_region_index > $past(m_region_index)))
    `MRFC_ASSERT_NEXT(a_same_byte, aclk, aresetn, m_valid && m_ready && !m_last_of_run, $stable(m_out_byte))
    // a full queue implies the emitter is busy
    `MRFC_ASSERT_SAME(a_full_busy, aclk, aresetn, q_stat.full, m_valid)

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
    import mrfc_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_BYTES   = 62;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } src_byte_t;

    typedef struct packed {
        logic [IDX_W-1:0] region;
        logic [7:0]       data;
        logic [OFS_W-1:0] offset;
        logic             last;
    } crop_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_sample_byte = 8'h00;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [IDX_W-1:0]      m_region_index;
    logic [7:0]            m_out_byte;
    logic [OFS_W-1:0]      m_out_offset;
    logic                  m_last_of_run;

    // Shadow of the block's registers and stream position
    logic [DIM_W-1:0] cur_width   = WIDTH_RST;
    logic [DIM_W-1:0] cur_height  = HEIGHT_RST;
    logic [2:0]       cur_format  = FMT_I420;
    logic [CNT_W-1:0] cur_regions = COUNT_RST;
    logic [63:0]      cur_rect [REGION_SLOTS] = '{default: '0};
    int unsigned      plane_pos = 0;
    int unsigned      row_pos   = 0;
    int unsigned      col_pos   = 0;
    logic [OFS_W-1:0] region_ofs [REGION_SLOTS] = '{default: '0};

    src_byte_t    pending_bytes [$];
    crop_result_t expected_crops [$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int          sink_hold      = 0;
    int          err_count      = 0;
    int          quiet_cycles   = 0;
    logic        in_taken       = 1'b0;

    multi_region_frame_crop i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_byte  (s_sample_byte),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_region_index (m_region_index),
        .m_out_byte     (m_out_byte),
        .m_out_offset   (m_out_offset),
        .m_last_of_run  (m_last_of_run)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    function automatic logic [2:0] active_format();
        return (cur_format > FMT_RGB32) ? FMT_I420 : cur_format;
    endfunction

    function automatic int unsigned plane_count(input logic [2:0] fmt);
        if (fmt >= FMT_RGB555) return 1;
        return (fmt == FMT_I420) ? 3 : 2;
    endfunction

    function automatic int unsigned bytes_per_pixel(input logic [2:0] fmt);
        if (fmt == FMT_RGB24) return 3;
        if (fmt == FMT_RGB32) return 4;
        return 2;
    endfunction

    function automatic void plane_shape(input logic [2:0] fmt, input int unsigned plane,
                                        output int unsigned rows, output int unsigned rowbytes);
        int unsigned w;
        int unsigned h;
        w = clamp_dim(cur_width);
        h = clamp_dim(cur_height);
        if (fmt >= FMT_RGB555) begin
            rows     = h;
            rowbytes = w * bytes_per_pixel(fmt);
        end else if (plane == 0) begin
            rows     = h;
            rowbytes = w;
        end else begin
            rows     = h >> 1;
            rowbytes = (fmt == FMT_I420) ? (w >> 1) : w;
        end
    endfunction

    function automatic int unsigned frame_size();
        logic [2:0]  fmt;
        int unsigned rows;
        int unsigned rowbytes;
        int unsigned total;
        int unsigned p;
        fmt   = active_format();
        total = 0;
        for (p = 0; p < plane_count(fmt); p++) begin
            plane_shape(fmt, p, rows, rowbytes);
            total += rows * rowbytes;
        end
        return total;
    endfunction

    function automatic void restart_position();
        plane_pos  = 0;
        row_pos    = 0;
        col_pos    = 0;
        region_ofs = '{default: '0};
    endfunction

    // Work out the beats one source byte causes and advance the stream position
    function automatic void crop_byte(input logic [7:0] data, input logic start);
        logic [2:0]   fmt;
        int unsigned  np, p, rows, rowbytes, lrow, bpp, n, nhit, j;
        int unsigned  x0, y0, x1, y1, tlx, brx, tly, bry, lo, hi;
        crop_result_t hits [REGION_SLOTS];
        if (start) restart_position();
        fmt = active_format();
        np  = plane_count(fmt);
        p   = (plane_pos < np) ? plane_pos : np - 1;
        plane_shape(fmt, p, rows, rowbytes);
        bpp  = bytes_per_pixel(fmt);
        n    = (cur_regions > REGION_SLOTS) ? REGION_SLOTS : cur_regions;
        nhit = 0;
        if (row_pos < rows && col_pos < rowbytes) begin
            // chroma rows sit on even luma rows
            lrow = (fmt < FMT_RGB555 && p != 0) ? row_pos * 2 : row_pos;
            for (j = 0; j < n; j++) begin
                x0  = cur_rect[j][15:0];
                y0  = cur_rect[j][31:16];
                x1  = cur_rect[j][47:32];
                y1  = cur_rect[j][63:48];
                tlx = (x0 <= x1) ? x0 : x1;
                brx = (x0 <= x1) ? x1 : x0;
                tly = (y0 <= y1) ? y0 : y1;
                bry = (y0 <= y1) ? y1 : y0;
                tlx = tlx + (tlx & 1);
                brx = brx & ~32'd1;
                if (fmt >= FMT_RGB555) begin
                    lo = tlx * bpp;
                    hi = brx * bpp;
                end else if (p != 0 && fmt == FMT_I420) begin
                    lo = tlx >> 1;
                    hi = brx >> 1;
                end else begin
                    lo = tlx;
                    hi = brx;
                end
                if (lrow >= tly && lrow < bry && col_pos >= lo && col_pos < hi) begin
                    hits[nhit].region = IDX_W'(j);
                    hits[nhit].data   = data;
                    hits[nhit].offset = region_ofs[j];
                    hits[nhit].last   = 1'b0;
                    region_ofs[j]     = region_ofs[j] + 1'b1;
                    nhit++;
                end
            end
            for (j = 0; j < nhit; j++) begin
                hits[j].last = (j == nhit - 1);
                expected_crops.push_back(hits[j]);
            end
        end
        col_pos++;
        if (col_pos >= rowbytes) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) begin
                row_pos = 0;
                plane_pos++;
                if (plane_pos >= np) restart_position();
            end
        end
    endfunction

    function automatic logic [63:0] pack_rect(input logic [15:0] x0, input logic [15:0] y0,
                                              input logic [15:0] x1, input logic [15:0] y1);
        return {y1, x1, y0, x0};
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_FRAME_WIDTH:  cur_width   = value[DIM_W-1:0];
            CFG_FRAME_HEIGHT: cur_height  = value[DIM_W-1:0];
            CFG_PIXEL_FORMAT: cur_format  = value[2:0];
            CFG_REGION_COUNT: cur_regions = value[CNT_W-1:0];
            CFG_RECT_ZERO:    cur_rect[0] = value;
            CFG_RECT_ONE:     cur_rect[1] = value;
            CFG_RECT_TWO:     cur_rect[2] = value;
            CFG_RECT_THREE:   cur_rect[3] = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [2:0] fmt, input logic [CNT_W-1:0] cnt,
                                input logic [63:0] rects [REGION_SLOTS]);
        write_reg(CFG_FRAME_WIDTH, 64'(w));
        write_reg(CFG_FRAME_HEIGHT, 64'(h));
        write_reg(CFG_PIXEL_FORMAT, 64'(fmt));
        write_reg(CFG_REGION_COUNT, 64'(cnt));
        write_reg(CFG_RECT_ZERO, rects[0]);
        write_reg(CFG_RECT_ONE, rects[1]);
        write_reg(CFG_RECT_TWO, rects[2]);
        write_reg(CFG_RECT_THREE, rects[3]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every byte is taken and every expected beat has arrived
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || expected_crops.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Source side
    always @(negedge aclk) begin
        src_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_bytes.pop_front();
                s_valid       <= 1'b1;
                s_sample_byte <= nxt.data;
                s_frame_start <= nxt.start;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Sink side
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check result beats and predict from accepted source beats
    always @(posedge aclk) begin
        crop_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_crops.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat: region %0d byte %02h offset %0d",
                                              m_region_index, m_out_byte, m_out_offset));
                end else begin
                    want = expected_crops.pop_front();
                    if (m_region_index !== want.region)
                        report_mismatch($sformatf("region_index: got %0d, want %0d",
                                                  m_region_index, want.region));
                    if (m_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte: got %02h, want %02h",
                                                  m_out_byte, want.data));
                    if (m_out_offset !== want.offset)
                        report_mismatch($sformatf("out_offset: got %0d, want %0d",
                                                  m_out_offset, want.offset));
                    if (m_last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run: got %0b, want %0b",
                                                  m_last_of_run, want.last));
                end
            end
            if (s_valid && s_ready) crop_byte(s_sample_byte, s_frame_start);
        end
        in_taken = aresetn && s_valid && s_ready;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
                     quiet_cycles, expected_crops.size());
            $display("multi_region_frame_crop verification failed");
            $finish;
        end
    end

    initial begin
        logic [DIM_W-1:0] w, h;
        logic [2:0]       fmt;
        logic [CNT_W-1:0] cnt;
        logic [63:0]      rects [REGION_SLOTS];
        logic [2:0]       fmt_order [8];
        src_byte_t        item;
        int unsigned      ph, j, k, n, len, fbytes, target, xr, yr;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: one 4x4 i420 frame through four regions, then the wrap
        rects[0] = pack_rect(16'd0, 16'd0, 16'd4, 16'd4);        // whole frame
        rects[1] = pack_rect(16'd3, 16'd3, 16'd1, 16'd1);        // rounds to nothing
        rects[2] = pack_rect(16'hFFFF, 16'hFFFF, 16'd2, 16'd1);  // clipped at frame edge
        rects[3] = pack_rect(16'd2, 16'd4, 16'd0, 16'd2);        // swapped corners
        apply_config(13'd4, 13'd4, FMT_I420, 3'd4, rects);
        for (k = 0; k < 25; k++) begin
            item.data  = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'(k * 37 + 5);
            item.start = (k == 0);
            pending_bytes.push_back(item);
        end
        wait_idle();

        fmt_order = '{FMT_RGB24, FMT_NV12, FMT_RGB32, 3'd7,
                      FMT_NV21, FMT_RGB555, FMT_RGB565, FMT_I420};
        for (ph = 0; ph < 8; ph++) begin
            w      = DIM_W'($urandom_range(2, 6));
            h      = DIM_W'($urandom_range(2, 4));
            fmt    = fmt_order[ph];
            cnt    = CNT_W'($urandom_range(1, 4));
            target = PHASE_BYTES;
            case (ph)
                1: begin w = 13'd1; h = 13'd0; end
                2: begin w = 13'h1FFF; h = 13'h1FFF; cnt = 3'd7; end
                4: begin w = 13'd4096; h = 13'd2; end
                5: begin cnt = 3'd0; target = 20; end
                6: begin w = 13'd2; h = 13'd2; end
                default: ;
            endcase
            xr = ((clamp_dim(w) > 16) ? 16 : clamp_dim(w)) + 2;
            yr = ((clamp_dim(h) > 16) ? 16 : clamp_dim(h)) + 2;
            for (j = 0; j < REGION_SLOTS; j++) begin
                if ($urandom_range(4) == 0)
                    rects[j] = {$urandom, $urandom};
                else
                    rects[j] = pack_rect(16'($urandom_range(xr)), 16'($urandom_range(yr)),
                                         16'($urandom_range(xr)), 16'($urandom_range(yr)));
            end
            if (ph == 0) begin
                cnt = 3'd4;
                for (j = 0; j < REGION_SLOTS; j++)
                    rects[j] = pack_rect(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
            end
            if (ph == 2) begin
                rects[2] = '0;
                rects[3] = '1;
            end
            apply_config(w, h, fmt, cnt, rects);

            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            // back up the result side while the source keeps offering
            if (ph == 0) sink_hold = HOLD_CYCLES;

            // mostly whole frames, some cut short, a few stray frame starts
            fbytes = frame_size();
            n = 0;
            while (n < target) begin
                len = fbytes;
                if ($urandom_range(7) == 0) len = $urandom_range(1, fbytes);
                if (len > target - n) len = target - n;
                for (k = 0; k < len; k++) begin
                    item.data  = 8'($urandom);
                    item.start = (k == 0) ? ($urandom_range(4) != 0) : ($urandom_range(29) == 0);
                    pending_bytes.push_back(item);
                end
                n += len;
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("multi_region_frame_crop verification clean");
        else
            $display("multi_region_frame_crop verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/mrfc_pkg.sv
rtl/mrfc_front.sv
rtl/mrfc_queue.sv
rtl/mrfc_back.sv
rtl/multi_region_frame_crop.sv
tb/tb_top.sv
